// ----- sv/pfa_pkg.sv -----
package pfa_pkg;

  // fixed field widths of the request and response transactions
  localparam int PAGE_W  = 10;
  localparam int TABLE_W = 2;

  // default sizing, handed down from the top level
  localparam int MAX_PAGES_DEF     = 1024;
  localparam int INITIAL_PAGES_DEF = 16;
  localparam int TABLES_DEF        = 4;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_SPACE = 2'd1,
    ST_BAD_PAGE     = 2'd2
  } status_t;

endpackage

// ----- sv/pfa_req_if.sv -----
interface pfa_req_if;
  logic                             valid;
  logic                             ready;
  pfa_pkg::cmd_t                    command;
  logic [pfa_pkg::TABLE_W-1:0]      table_req;
  logic [pfa_pkg::PAGE_W-1:0]       page;

  modport source (output valid, output command, output table_req, output page, input ready);
  modport sink   (input valid, input command, input table_req, input page, output ready);
endinterface

// ----- sv/pfa_rsp_if.sv -----
interface pfa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pfa_pkg::PAGE_W-1:0]  page_out;
  pfa_pkg::status_t            status;

  modport source (output valid, output page_out, output status, input ready);
  modport sink   (input valid, input page_out, input status, output ready);
endinterface

// ----- sv/pfa_ram.sv -----
module pfa_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/pfa_ctrl.sv -----
module pfa_ctrl #(
  parameter int MAX_PAGES     = pfa_pkg::MAX_PAGES_DEF,
  parameter int INITIAL_PAGES = pfa_pkg::INITIAL_PAGES_DEF,
  parameter int TABLES        = pfa_pkg::TABLES_DEF,
  parameter int PW            = $clog2(MAX_PAGES),
  parameter int CW            = $clog2(MAX_PAGES + 1),
  parameter int TW            = (TABLES > 1) ? $clog2(TABLES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  pfa_req_if.sink          req,
  pfa_rsp_if.source        rsp,
  // next-link store
  output logic             link_we,
  output logic [TW+PW-1:0] link_waddr,
  output logic [PW-1:0]    link_wdata,
  output logic [TW+PW-1:0] link_raddr,
  input  logic [PW-1:0]    link_rdata,
  // per-table head and count store
  output logic             hd_we,
  output logic [TW-1:0]    hd_waddr,
  output logic [PW+CW-1:0] hd_wdata,
  output logic [TW-1:0]    hd_raddr,
  input  logic [PW+CW-1:0] hd_rdata
);

  localparam int START_PAGES = (INITIAL_PAGES > MAX_PAGES) ? MAX_PAGES : INITIAL_PAGES;
  localparam int XW  = (CW > pfa_pkg::PAGE_W) ? CW : pfa_pkg::PAGE_W;
  localparam int TXW = (TW > pfa_pkg::TABLE_W) ? TW : pfa_pkg::TABLE_W;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_LOOK = 6'b000100,
    S_POP  = 6'b001000,
    S_GROW = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  pfa_pkg::cmd_t           cmd_r, cmd_nxt;
  logic [TW-1:0]           tbl_r, tbl_nxt;
  logic                    tok_r, tok_nxt;
  logic [pfa_pkg::PAGE_W-1:0] page_r, page_nxt;
  logic [PW-1:0]           head_r, head_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [PW-1:0]           p_r, p_nxt;
  logic                    first_r, first_nxt;
  logic [TW-1:0]           init_t_r, init_t_nxt;
  logic [PW-1:0]           init_p_r, init_p_nxt;
  logic [pfa_pkg::PAGE_W-1:0] res_page_r, res_page_nxt;
  pfa_pkg::status_t        res_status_r, res_status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [pfa_pkg::PAGE_W-1:0] out_page_r, out_page_nxt;
  pfa_pkg::status_t        out_status_r, out_status_nxt;

  logic                    accept;
  logic                    out_free;
  logic                    fin;
  logic [PW-1:0]           fin_page;
  pfa_pkg::status_t        fin_status;
  logic [PW-1:0]           head_q;
  logic [CW-1:0]           cnt_q;
  logic [XW-1:0]           page_x;
  logic [PW-1:0]           pg_idx;
  logic [CW:0]             grown;
  logic [PW-1:0]           gm1;
  logic [XW-1:0]           fin_page_x;
  logic [TXW-1:0]          req_t_x;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid_r || rsp.ready;
  assign head_q   = hd_rdata[CW +: PW];
  assign cnt_q    = hd_rdata[CW-1:0];
  assign page_x   = XW'(page_r);
  assign pg_idx   = page_x[PW-1:0];
  assign grown    = {1'b0, cnt_q} << 1;
  assign gm1      = PW'(count_r - CW'(1));
  assign req_t_x  = TXW'(req.table_req);

  assign req.ready    = (state_r == S_IDLE);
  assign rsp.valid    = out_valid_r;
  assign rsp.page_out = out_page_r;
  assign rsp.status   = out_status_r;

  assign hd_raddr = req_t_x[TW-1:0];

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    tbl_nxt        = tbl_r;
    tok_nxt        = tok_r;
    page_nxt       = page_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    p_nxt          = p_r;
    first_nxt      = first_r;
    init_t_nxt     = init_t_r;
    init_p_nxt     = init_p_r;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    fin            = 1'b0;
    fin_page       = '0;
    fin_status     = pfa_pkg::ST_OK;
    link_we        = 1'b0;
    link_waddr     = {tbl_r, p_r};
    link_wdata     = '0;
    link_raddr     = {tbl_r, head_q};
    hd_we          = 1'b0;
    hd_waddr       = tbl_r;
    hd_wdata       = {head_r, count_r};

    case (state_r)
      S_INIT: begin
        // write the initial downward chain of every table
        link_we    = 1'b1;
        link_waddr = {init_t_r, init_p_r};
        link_wdata = (init_p_r == '0) ? '0 : init_p_r - PW'(1);
        if (init_p_r == '0) begin
          hd_we    = 1'b1;
          hd_waddr = init_t_r;
          hd_wdata = {PW'(START_PAGES - 1), CW'(START_PAGES)};
        end
        if (init_p_r == PW'(START_PAGES - 1)) begin
          init_p_nxt = '0;
          init_t_nxt = init_t_r + TW'(1);
          if (init_t_r == TW'(TABLES - 1)) begin
            state_nxt = S_IDLE;
          end
        end else begin
          init_p_nxt = init_p_r + PW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = req.command;
          tbl_nxt   = req_t_x[TW-1:0];
          tok_nxt   = (int'(req.table_req) < TABLES);
          page_nxt  = req.page;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!tok_r) begin
          fin        = 1'b1;
          fin_status = pfa_pkg::ST_BAD_PAGE;
        end else if (cmd_r == pfa_pkg::CMD_FREE) begin
          fin = 1'b1;
          if (page_x == '0 || page_x >= XW'(cnt_q)) begin
            fin_status = pfa_pkg::ST_BAD_PAGE;
          end else begin
            link_we    = 1'b1;
            link_waddr = {tbl_r, pg_idx};
            link_wdata = head_q;
            hd_we      = 1'b1;
            hd_wdata   = {pg_idx, cnt_q};
          end
        end else if (head_q != '0) begin
          head_nxt  = head_q;
          count_nxt = cnt_q;
          state_nxt = S_POP;
        end else if (grown > (CW+1)'(MAX_PAGES)) begin
          fin        = 1'b1;
          fin_status = pfa_pkg::ST_OUT_OF_SPACE;
        end else begin
          p_nxt     = cnt_q[PW-1:0];
          count_nxt = grown[CW-1:0];
          first_nxt = 1'b1;
          state_nxt = S_GROW;
        end
      end
      S_POP: begin
        hd_we    = 1'b1;
        hd_wdata = {link_rdata, count_r};
        fin      = 1'b1;
        fin_page = head_r;
      end
      S_GROW: begin
        // one new link a cycle, lowest new page ends the list
        link_we    = 1'b1;
        link_waddr = {tbl_r, p_r};
        link_wdata = first_r ? '0 : p_r - PW'(1);
        first_nxt  = 1'b0;
        p_nxt      = p_r + PW'(1);
        if (p_r == gm1) begin
          hd_we    = 1'b1;
          hd_wdata = {gm1 - PW'(1), count_r};
          fin      = 1'b1;
          fin_page = gm1;
        end
      end
      S_HOLD: begin
        fin        = 1'b1;
        fin_page   = PW'(res_page_r);
        fin_status = res_status_r;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    fin_page_x = XW'(fin_page);
    if (fin) begin
      res_page_nxt   = fin_page_x[pfa_pkg::PAGE_W-1:0];
      res_status_nxt = fin_status;
      state_nxt      = out_free ? S_IDLE : S_HOLD;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !rsp.ready;
    out_page_nxt   = out_page_r;
    out_status_nxt = out_status_r;
    if (fin && out_free) begin
      out_valid_nxt  = 1'b1;
      out_page_nxt   = fin_page_x[pfa_pkg::PAGE_W-1:0];
      out_status_nxt = fin_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_t_r    <= '0;
      init_p_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_t_r    <= init_t_nxt;
      init_p_r    <= init_p_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    tbl_r        <= tbl_nxt;
    tok_r        <= tok_nxt;
    page_r       <= page_nxt;
    head_r       <= head_nxt;
    count_r      <= count_nxt;
    p_r          <= p_nxt;
    first_r      <= first_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
    out_page_r   <= out_page_nxt;
    out_status_r <= out_status_nxt;
  end

  // a table's head always lies below its page count, which never exceeds MAX_PAGES
  a_head_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && tok_r) |-> (XW'(head_q) < XW'(cnt_q) && cnt_q <= CW'(MAX_PAGES)))
    else $error("head or count out of range");

  // a popped link points inside the table
  a_link_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (XW'(link_rdata) < XW'(count_r)))
    else $error("popped link out of range");

  // growth walks only the new upper half
  a_grow_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GROW) |-> (XW'(p_r) < XW'(count_r) && XW'(p_r) >= XW'(count_r >> 1)))
    else $error("growth pointer out of range");

  // failed requests never hand out a page
  a_fail_no_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != pfa_pkg::ST_OK) |-> (out_page_r == '0))
    else $error("page handed out with error status");

endmodule

// ----- sv/page_free_list_allocator.sv -----
// channel   | dir | payload                          | handshake
// ----------+-----+----------------------------------+--------------
// in_chan   | in  | command, table_req, page         | valid/ready
// out_chan  | out | page_out, status                 | valid/ready
//
// one transaction in flight: free, bad table and out_of_space finish in the lookup state,
//   an allocate with a non-empty list reads head/count, then the link, and pops the head
// an allocate that grows the list walks the new upper half of its pages, one link
//   write a cycle into the next-link store
// after reset an initialisation pass writes min(INITIAL_PAGES, MAX_PAGES) links for each
//   of the TABLES tables to build the starting chains; in_chan.ready stays low
// a stalled out_chan holds the finished transaction in a result register;
//   in_chan is taken again once that result reaches the output register
module page_free_list_allocator #(
  parameter int MAX_PAGES     = pfa_pkg::MAX_PAGES_DEF,
  parameter int INITIAL_PAGES = pfa_pkg::INITIAL_PAGES_DEF,
  parameter int TABLES        = pfa_pkg::TABLES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pfa_req_if.sink   in_chan,
  pfa_rsp_if.source out_chan
);

  // page index, page count and table index widths
  localparam int PW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int TW = (TABLES > 1) ? $clog2(TABLES) : 1;

  // next-link store port, addressed by {table, page}
  logic             link_we;
  logic [TW+PW-1:0] link_waddr;
  logic [PW-1:0]    link_wdata;
  logic [TW+PW-1:0] link_raddr;
  logic [PW-1:0]    link_rdata;

  // head/count store port, one word {free head, page count} per table
  logic             hd_we;
  logic [TW-1:0]    hd_waddr;
  logic [PW+CW-1:0] hd_wdata;
  logic [TW-1:0]    hd_raddr;
  logic [PW+CW-1:0] hd_rdata;

  // sequencer: lookup, pop, growth walk and response staging
  pfa_ctrl #(
    .MAX_PAGES     (MAX_PAGES),
    .INITIAL_PAGES (INITIAL_PAGES),
    .TABLES        (TABLES),
    .PW            (PW),
    .CW            (CW),
    .TW            (TW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_chan),
    .rsp        (out_chan),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .hd_we      (hd_we),
    .hd_waddr   (hd_waddr),
    .hd_wdata   (hd_wdata),
    .hd_raddr   (hd_raddr),
    .hd_rdata   (hd_rdata)
  );

  // per-page links of every table
  pfa_ram #(
    .DATA_W (PW),
    .ADDR_W (TW + PW)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // free head and page count of every table
  pfa_ram #(
    .DATA_W (PW + CW),
    .ADDR_W (TW)
  ) u_head_ram (
    .clk   (clk),
    .we    (hd_we),
    .waddr (hd_waddr),
    .wdata (hd_wdata),
    .raddr (hd_raddr),
    .rdata (hd_rdata)
  );

endmodule

// ----- verif/tb_page_free_list_allocator.sv -----
module tb_page_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  // sizing follows the block's defaults
  localparam int MAXP        = pfa_pkg::MAX_PAGES_DEF;
  localparam int NTAB        = pfa_pkg::TABLES_DEF;
  localparam int START_PAGES = (pfa_pkg::INITIAL_PAGES_DEF > pfa_pkg::MAX_PAGES_DEF)
                               ? pfa_pkg::MAX_PAGES_DEF : pfa_pkg::INITIAL_PAGES_DEF;

  // run shape
  localparam int RANDOM_ITEMS   = 280;
  localparam int GROW_ALLOCS    = 300;   // table 3 doubles several times, up to 512 pages
  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 4000;  // worst growth walk plus hold-off, several times over
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_PRINTS     = 50;

  typedef struct packed {
    pfa_pkg::cmd_t                command;
    logic [pfa_pkg::TABLE_W-1:0]  table_req;
    logic [pfa_pkg::PAGE_W-1:0]   page;
  } page_req_t;

  typedef struct packed {
    logic [pfa_pkg::PAGE_W-1:0]   page_out;
    pfa_pkg::status_t             status;
  } page_rsp_t;

  logic clk;
  logic rst_n;

  pfa_req_if req_bus ();
  pfa_rsp_if rsp_bus ();

  page_free_list_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_bus),
    .out_chan (rsp_bus)
  );

  always #5 clk = ~clk;

  // shadow of the allocator: per-table head, page count and next-link store
  logic [pfa_pkg::PAGE_W-1:0] link_mem [0:NTAB*MAXP-1];
  logic [pfa_pkg::PAGE_W-1:0] head_pg  [0:NTAB-1];
  logic [pfa_pkg::PAGE_W:0]   pg_count [0:NTAB-1];

  page_req_t pending_reqs[$];     // requests waiting to be offered
  page_rsp_t awaited_replies[$];  // replies predicted, oldest first
  page_req_t held_list[$];        // pages handed out so far, candidates for a proper free

  page_req_t drive_item;
  page_rsp_t want_reply;

  logic idle_on;       // random idle bursts enabled on both sides
  logic hold_trigger;  // starts the long receiver hold-off
  int   hold_left;
  int   send_gap;
  int   rsp_gap;
  int   quiet_cycles;

  int fail_count;
  int n_requests;
  int n_granted;
  int n_freed;
  int n_rejected;
  int n_full;

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("mismatch at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
  endtask

  // rebuild the starting chains: page p links to p - 1, page 1 ends the list
  function automatic void clear_shadow();
    int t;
    int p;
    for (t = 0; t < NTAB; t++) begin
      for (p = 0; p < MAXP; p++)
        link_mem[t*MAXP + p] = '0;
      for (p = 1; p < START_PAGES; p++)
        link_mem[t*MAXP + p] = pfa_pkg::PAGE_W'(p - 1);
      pg_count[t] = (pfa_pkg::PAGE_W+1)'(START_PAGES);
      head_pg[t]  = pfa_pkg::PAGE_W'(START_PAGES - 1);
    end
  endfunction

  // applies one request to the shadow and returns the reply it must produce
  function automatic page_rsp_t allocate_or_free(page_req_t r);
    page_rsp_t res;
    page_req_t taken;
    int        t;
    int        grown;
    int        p;
    res.page_out = '0;
    res.status   = pfa_pkg::ST_OK;
    t = int'(r.table_req);
    if (t >= NTAB) begin
      // missing table, either command
      res.status = pfa_pkg::ST_BAD_PAGE;
    end else if (r.command == pfa_pkg::CMD_FREE) begin
      if (r.page == '0 || r.page >= pg_count[t]) begin
        res.status = pfa_pkg::ST_BAD_PAGE;
      end else begin
        // push, double frees included
        link_mem[t*MAXP + int'(r.page)] = head_pg[t];
        head_pg[t] = r.page;
      end
    end else begin
      if (head_pg[t] == '0) begin
        grown = 2 * int'(pg_count[t]);
        if (grown > MAXP) begin
          res.status = pfa_pkg::ST_OUT_OF_SPACE;
        end else begin
          // chain the new pages downward, lowest new page ends the list
          link_mem[t*MAXP + int'(pg_count[t])] = '0;
          for (p = int'(pg_count[t]) + 1; p < grown; p++)
            link_mem[t*MAXP + p] = pfa_pkg::PAGE_W'(p - 1);
          head_pg[t]  = pfa_pkg::PAGE_W'(grown - 1);
          pg_count[t] = (pfa_pkg::PAGE_W+1)'(grown);
        end
      end
      if (res.status == pfa_pkg::ST_OK) begin
        res.page_out = head_pg[t];
        head_pg[t]   = link_mem[t*MAXP + int'(res.page_out)];
        taken.command   = pfa_pkg::CMD_FREE;
        taken.table_req = r.table_req;
        taken.page      = res.page_out;
        held_list.insert(held_list.size(), taken);
      end
    end
    return res;
  endfunction

  // request driver: predicts at acceptance, idles only between transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      req_bus.valid     <= 1'b0;
      req_bus.command   <= pfa_pkg::CMD_ALLOC;
      req_bus.table_req <= '0;
      req_bus.page      <= '0;
      send_gap          <= 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        drive_item.command   = req_bus.command;
        drive_item.table_req = req_bus.table_req;
        drive_item.page      = req_bus.page;
        awaited_replies.insert(awaited_replies.size(), allocate_or_free(drive_item));
        n_requests++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          req_bus.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
          // idle burst of random length
          send_gap      <= $urandom_range(0, 14);
          req_bus.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          drive_item         = pending_reqs.pop_front();
          req_bus.valid     <= 1'b1;
          req_bus.command   <= drive_item.command;
          req_bus.table_req <= drive_item.table_req;
          req_bus.page      <= drive_item.page;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here so the monitor only sees a level
  always @(posedge clk) begin
    if (!rst_n)
      hold_left <= 0;
    else if (hold_trigger)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // reply monitor: checks each accepted transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
      rsp_gap       <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("reply with nothing outstanding, page_out", int'(rsp_bus.page_out), -1);
        end else begin
          want_reply = awaited_replies.pop_front();
          if (rsp_bus.page_out !== want_reply.page_out)
            report_mismatch("page_out", int'(rsp_bus.page_out), int'(want_reply.page_out));
          if (rsp_bus.status !== want_reply.status)
            report_mismatch("status", int'(rsp_bus.status), int'(want_reply.status));
          case (want_reply.status)
            pfa_pkg::ST_OK: begin
              if (want_reply.page_out != '0) n_granted++;
              else n_freed++;
            end
            pfa_pkg::ST_OUT_OF_SPACE: n_full++;
            default:                  n_rejected++;
          endcase
        end
      end
      if (hold_left != 0) begin
        rsp_bus.ready <= 1'b0;
      end else if (rsp_gap != 0) begin
        rsp_gap       <= rsp_gap - 1;
        rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        rsp_gap       <= $urandom_range(0, 14);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb_page_free_list_allocator: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // keeps the request queue short so the generator sees fresh shadow state
  task automatic queue_request(input pfa_pkg::cmd_t cmd, input int tbl, input int pg);
    page_req_t item;
    while (pending_reqs.size() >= 2)
      @(negedge clk);
    item.command   = cmd;
    item.table_req = pfa_pkg::TABLE_W'(tbl);
    item.page      = pfa_pkg::PAGE_W'(pg);
    pending_reqs.insert(pending_reqs.size(), item);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_bus.valid || awaited_replies.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int        i;
    int        roll;
    int        tbl;
    int        pick;
    int        biggest;
    page_req_t held;

    clk          = 1'b0;
    rst_n        = 1'b0;
    idle_on      = 1'b0;
    hold_trigger = 1'b0;
    fail_count   = 0;
    n_requests   = 0;
    n_granted    = 0;
    n_freed      = 0;
    n_rejected   = 0;
    n_full       = 0;
    quiet_cycles = 0;
    hold_left    = 0;
    send_gap     = 0;
    rsp_gap      = 0;

    req_bus.valid     = 1'b0;
    req_bus.command   = pfa_pkg::CMD_ALLOC;
    req_bus.table_req = '0;
    req_bus.page      = '0;
    rsp_bus.ready     = 1'b0;
    clear_shadow();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: first pops, rejected frees at both ends of the page range,
    // a double free, and table 2 drained until it has to grow
    queue_request(pfa_pkg::CMD_ALLOC, 0, 1023);
    queue_request(pfa_pkg::CMD_FREE,  0, 15);
    queue_request(pfa_pkg::CMD_FREE,  0, 0);
    queue_request(pfa_pkg::CMD_FREE,  0, 16);
    queue_request(pfa_pkg::CMD_FREE,  3, 1023);
    queue_request(pfa_pkg::CMD_FREE,  1, 5);
    queue_request(pfa_pkg::CMD_FREE,  1, 5);
    queue_request(pfa_pkg::CMD_ALLOC, 1, 0);
    queue_request(pfa_pkg::CMD_ALLOC, 1, 0);
    for (i = 0; i < 16; i++)
      queue_request(pfa_pkg::CMD_ALLOC, 2, $urandom_range(0, 1023));

    // sender pause until every reply is back
    wait_drained();

    // grow table 3 through several doublings, with idling and, part way
    // through, the receiver holding off while requests keep coming
    @(negedge clk);
    idle_on = 1'b1;
    for (i = 0; i < GROW_ALLOCS; i++) begin
      if (i == 150) begin
        hold_trigger = 1'b1;
        @(negedge clk);
        hold_trigger = 1'b0;
      end
      queue_request(pfa_pkg::CMD_ALLOC, 3, $urandom_range(0, 1023));
    end

    // random mix in four quarters: idle, no idle, idle, and no idle
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % (RANDOM_ITEMS / 4) == 0) begin
        if (i == RANDOM_ITEMS / 2)
          wait_drained();
        @(negedge clk);
        idle_on = (i < 3 * RANDOM_ITEMS / 4) && ((i / (RANDOM_ITEMS / 4)) % 2 == 0);
      end
      roll = $urandom_range(0, 99);
      tbl  = $urandom_range(0, NTAB - 1);
      if (roll < 45 || (roll < 85 && held_list.size() == 0)) begin
        queue_request(pfa_pkg::CMD_ALLOC, tbl, $urandom_range(0, 1023));
      end else if (roll < 85) begin
        // proper free of a page handed out earlier
        pick = $urandom_range(0, held_list.size() - 1);
        held = held_list[pick];
        held_list.delete(pick);
        queue_request(pfa_pkg::CMD_FREE, int'(held.table_req), int'(held.page));
      end else if (roll < 93) begin
        // in range but maybe already free
        queue_request(pfa_pkg::CMD_FREE, tbl, $urandom_range(1, int'(pg_count[tbl]) - 1));
      end else begin
        // noise, mostly out of range
        queue_request(pfa_pkg::CMD_FREE, tbl, $urandom_range(0, 1023));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    biggest = 0;
    for (i = 0; i < NTAB; i++)
      if (int'(pg_count[i]) > biggest) biggest = int'(pg_count[i]);
    $display("%0d requests: %0d pages granted, %0d frees taken, %0d rejected, %0d out of space",
             n_requests, n_granted, n_freed, n_rejected, n_full);
    $display("largest table reached %0d pages, %0d mismatches", biggest, fail_count);
    if (fail_count == 0)
      $display("tb_page_free_list_allocator: PASS");
    else
      $display("tb_page_free_list_allocator: FAIL");
    $finish;
  end

endmodule
